// File: src/charge_weighted_flow_vector_top_defines.svh
// Assertion helpers shared by the flow vector RTL.
// Each macro expects clk and rst_n in scope; checks are off while in reset.
`ifndef CHARGE_WEIGHTED_FLOW_VECTOR_TOP_DEFINES_SVH
`define CHARGE_WEIGHTED_FLOW_VECTOR_TOP_DEFINES_SVH

// Same-cycle implication
`define CWFV_ASSERT_IMP(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication
`define CWFV_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: src/cwfv_pkg.sv
`default_nettype none

package cwfv_pkg;

    // Field and accumulator widths
    localparam int CHAN_W  = 6;
    localparam int CHG_W   = 12;
    localparam int SUM_W   = 34;
    localparam int TOT_W   = 18;
    localparam int TRIG_W  = 16;
    localparam int Q_W     = 16;

    // Event queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // One channel hit request
    typedef struct packed {
        logic [CHAN_W-1:0] channel;
        logic [CHG_W-1:0]  charge;
        logic              last;
    } in_t;

    // One normalized flow vector
    typedef struct packed {
        logic signed [Q_W-1:0] q_x;
        logic signed [Q_W-1:0] q_y;
        logic                  empty_res;
    } out_t;

    // Finished event sums handed from front to back
    typedef struct packed {
        logic [SUM_W-1:0] sum_cos;
        logic [SUM_W-1:0] sum_sin;
        logic [TOT_W-1:0] total;
    } evt_t;

    // Queue status seen by both sides
    typedef struct packed {
        logic [QCNT_W-1:0] count;
        logic              empty;
    } qstat_t;

    // cos(n*pi/8) in Q1.15, 1.0 clipped to 32767
    localparam logic signed [TRIG_W-1:0] COS_TAB [16] = '{
        16'sd32767,  16'sd30274,  16'sd23170,  16'sd12540,
        16'sd0,     -16'sd12540, -16'sd23170, -16'sd30274,
        16'h8000,   -16'sd30274, -16'sd23170, -16'sd12540,
        16'sd0,      16'sd12540,  16'sd23170,  16'sd30274
    };

    // Inner rings: channel mod 8 to sector
    localparam logic [2:0] INNER_SECTOR [8] = '{
        3'd5, 3'd4, 3'd3, 3'd2, 3'd6, 3'd7, 3'd0, 3'd1
    };

    // Outer ring: channel - 32 to sector
    localparam logic [3:0] OUTER_SECTOR [16] = '{
        4'd11, 4'd9,  4'd7, 4'd5, 4'd13, 4'd15, 4'd1, 4'd3,
        4'd10, 4'd8,  4'd6, 4'd4, 4'd12, 4'd14, 4'd0, 4'd2
    };

    // 2*phi as a multiple of pi/8
    function automatic logic [3:0] angle_index(logic [CHAN_W-1:0] ch);
        logic [2:0] isec;
        logic [3:0] osec;
        logic [3:0] n;
        isec = INNER_SECTOR[ch[2:0]];
        osec = OUTER_SECTOR[ch[3:0]];
        if (ch < 6'd32)
            n = {isec[1:0], 2'b10};
        else if (ch < 6'd48)
            n = {osec[2:0], 1'b1};
        else
            n = 4'd1;  // out-of-range channel acts as outer sector 0
        return n;
    endfunction

endpackage

`default_nettype wire

// File: src/cwfv_front.sv
`default_nettype none

module cwfv_front #(
    parameter int CHARGE_BITS = 12
) (
    input  wire                 clk,
    input  wire                 rst_n,
    input  wire                 hit_valid,
    output logic                hit_stall,
    input  cwfv_pkg::in_t       hit,
    input  cwfv_pkg::qstat_t    qstat,
    output logic                push,
    output cwfv_pkg::evt_t      evt
);
    import cwfv_pkg::*;

    // Charge bits kept from the ADC word
    localparam int KEEP_BITS = (CHARGE_BITS < CHG_W) ? CHARGE_BITS : CHG_W;
    localparam logic [CHG_W:0] MASK_WIDE = (CHG_W + 1)'((33'd1 << KEEP_BITS) - 33'd1);
    localparam logic [CHG_W-1:0] CHG_MASK = MASK_WIDE[CHG_W-1:0];
    localparam int PROD_W = TRIG_W + CHG_W + 1;

    logic                     take;
    logic [3:0]               ang;
    logic [3:0]               ang_sin;

    // Stage 1: table lookup
    logic                     s1_valid_reg;
    logic                     s1_last_reg;
    logic signed [TRIG_W-1:0] s1_cos_reg;
    logic signed [TRIG_W-1:0] s1_sin_reg;
    logic [CHG_W-1:0]         s1_chg_reg;

    // Stage 2: weighted products
    logic                     s2_valid_reg;
    logic                     s2_last_reg;
    logic signed [PROD_W-1:0] s2_prod_c_reg;
    logic signed [PROD_W-1:0] s2_prod_s_reg;
    logic [CHG_W-1:0]         s2_chg_reg;
    logic signed [PROD_W-1:0] prod_c_next;
    logic signed [PROD_W-1:0] prod_s_next;

    // Event accumulators
    logic [SUM_W-1:0]         acc_cos_reg;
    logic [SUM_W-1:0]         acc_sin_reg;
    logic [TOT_W-1:0]         acc_tot_reg;
    logic [SUM_W-1:0]         acc_cos_next;
    logic [SUM_W-1:0]         acc_sin_next;
    logic [TOT_W-1:0]         acc_tot_next;
    logic [SUM_W-1:0]         sum_c;
    logic [SUM_W-1:0]         sum_s;
    logic [TOT_W-1:0]         sum_t;

    logic [1:0]               inflight;

    // Hold off requests while the queue could overflow with events in flight
    always_comb
    begin
        inflight  = {1'b0, s1_valid_reg & s1_last_reg} + {1'b0, s2_valid_reg & s2_last_reg};
        hit_stall = (4'(qstat.count) + 4'(inflight)) >= 4'(QUEUE_DEPTH);
        take      = hit_valid && !hit_stall;
        ang       = angle_index(hit.channel);
        ang_sin   = ang + 4'd12;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= take;
            s2_valid_reg <= s1_valid_reg;
        end
    end

    // Stage 1 payload
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            s1_last_reg <= hit.last;
            s1_cos_reg  <= COS_TAB[ang];
            s1_sin_reg  <= COS_TAB[ang_sin];
            s1_chg_reg  <= hit.charge & CHG_MASK;
        end
    end

    // Stage 2 payload: one multiplier per component
    always_comb
    begin
        prod_c_next = s1_cos_reg * $signed({1'b0, s1_chg_reg});
        prod_s_next = s1_sin_reg * $signed({1'b0, s1_chg_reg});
    end

    always_ff @(posedge clk)
    begin
        if (s1_valid_reg)
        begin
            s2_last_reg   <= s1_last_reg;
            s2_prod_c_reg <= prod_c_next;
            s2_prod_s_reg <= prod_s_next;
            s2_chg_reg    <= s1_chg_reg;
        end
    end

    // Accumulate; the last hit pushes the sums and clears for the next event
    always_comb
    begin
        sum_c = acc_cos_reg + SUM_W'(s2_prod_c_reg);
        sum_s = acc_sin_reg + SUM_W'(s2_prod_s_reg);
        sum_t = acc_tot_reg + TOT_W'(s2_chg_reg);
        acc_cos_next = acc_cos_reg;
        acc_sin_next = acc_sin_reg;
        acc_tot_next = acc_tot_reg;
        if (s2_valid_reg)
        begin
            if (s2_last_reg)
            begin
                acc_cos_next = '0;
                acc_sin_next = '0;
                acc_tot_next = '0;
            end
            else
            begin
                acc_cos_next = sum_c;
                acc_sin_next = sum_s;
                acc_tot_next = sum_t;
            end
        end
        push        = s2_valid_reg && s2_last_reg;
        evt.sum_cos = sum_c;
        evt.sum_sin = sum_s;
        evt.total   = sum_t;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_cos_reg <= '0;
            acc_sin_reg <= '0;
            acc_tot_reg <= '0;
        end
        else
        begin
            acc_cos_reg <= acc_cos_next;
            acc_sin_reg <= acc_sin_next;
            acc_tot_reg <= acc_tot_next;
        end
    end

endmodule

`default_nettype wire

// File: src/cwfv_queue.sv
`default_nettype none
`include "charge_weighted_flow_vector_top_defines.svh"

module cwfv_queue (
    input  wire                 clk,
    input  wire                 rst_n,
    input  wire                 push,
    input  cwfv_pkg::evt_t      evt,
    input  wire                 pop,
    output cwfv_pkg::evt_t      head,
    output cwfv_pkg::qstat_t    qstat
);
    import cwfv_pkg::*;

    evt_t              mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg;
    logic [QPTR_W-1:0] wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_next;
    logic [QCNT_W-1:0] count_next;

    // Pointer and fill count update
    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
        head        = mem_reg[rd_ptr_reg];
        qstat.count = count_reg;
        qstat.empty = (count_reg == '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Event storage
    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= evt;
    end

    // Front must reserve room for every event still in its pipeline
    `CWFV_ASSERT_IMP(a_no_push_full, push, count_reg != QCNT_W'(QUEUE_DEPTH), "event pushed into full queue")
    `CWFV_ASSERT_IMP(a_no_pop_empty, pop, count_reg != '0, "event popped from empty queue")
    `CWFV_ASSERT_NEXT(a_count_up, push && !pop, count_reg == $past(count_reg) + 1'b1, "queue count lost a push")
    `CWFV_ASSERT_IMP(a_ptr_match, count_reg == '0, wr_ptr_reg == rd_ptr_reg, "pointers disagree on empty queue")

endmodule

`default_nettype wire

// File: src/cwfv_back.sv
`default_nettype none

module cwfv_back (
    input  wire                 clk,
    input  wire                 rst_n,
    input  cwfv_pkg::evt_t      head,
    input  cwfv_pkg::qstat_t    qstat,
    output logic                pop,
    output logic                res_valid,
    input  wire                 res_stall,
    output cwfv_pkg::out_t      res
);
    import cwfv_pkg::*;

    localparam int NUM_W     = SUM_W + 1;   // 2*|sum| + total
    localparam int DIV_W     = TOT_W + 1;   // 2*total
    localparam int REM_W     = DIV_W + 1;
    localparam int DIV_STEPS = NUM_W;
    localparam int CNT_W     = $clog2(DIV_STEPS);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_DIV  = 3'b010,
        ST_DONE = 3'b100
    } state_t;

    state_t           state_reg, state_next;
    logic             comp_reg, comp_next;          // 0: cosine, 1: sine
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [NUM_W-1:0] num_reg, num_next;            // dividend, shifts into quotient
    logic [REM_W-1:0] rem_reg, rem_next;
    logic [DIV_W-1:0] div_reg, div_next;
    logic             neg_reg, neg_next;
    logic [SUM_W-1:0] sin_sum_reg, sin_sum_next;
    logic [Q_W-1:0]   qx_reg, qx_next;
    logic [Q_W-1:0]   qy_reg, qy_next;
    logic             empty_reg, empty_next;
    logic             res_valid_reg, res_valid_next;
    out_t             res_reg, res_next;

    logic [REM_W-1:0] rem_sh;
    logic             ge;
    logic [REM_W-1:0] rem_step;
    logic [NUM_W-1:0] num_step;
    logic [Q_W-1:0]   q_sat;

    // Rounded dividend: 2*|sum| + total
    function automatic logic [NUM_W-1:0] div_num(logic [SUM_W-1:0] s, logic [TOT_W-1:0] t);
        logic [SUM_W-1:0] mag;
        mag = s[SUM_W-1] ? (~s + 1'b1) : s;
        return {mag, 1'b0} + NUM_W'(t);
    endfunction

    // Clip the quotient magnitude to Q1.15 and apply the sign
    function automatic logic [Q_W-1:0] sat_q(logic [NUM_W-1:0] q, logic neg);
        logic [Q_W-1:0] r;
        if (neg)
        begin
            if (q >= NUM_W'(32768))
                r = 16'h8000;
            else
                r = ~q[Q_W-1:0] + 1'b1;
        end
        else
        begin
            if (q >= NUM_W'(32767))
                r = 16'h7FFF;
            else
                r = q[Q_W-1:0];
        end
        return r;
    endfunction

    // One restoring division step
    always_comb
    begin
        rem_sh   = {rem_reg[REM_W-2:0], num_reg[NUM_W-1]};
        ge       = rem_sh >= {1'b0, div_reg};
        rem_step = ge ? rem_sh - {1'b0, div_reg} : rem_sh;
        num_step = {num_reg[NUM_W-2:0], ge};
        q_sat    = sat_q(num_step, neg_reg);
    end

    // Sequencer: pop an event, divide cosine then sine (none for an empty event), hand to output register
    always_comb
    begin
        state_next     = state_reg;
        comp_next      = comp_reg;
        cnt_next       = cnt_reg;
        num_next       = num_reg;
        rem_next       = rem_reg;
        div_next       = div_reg;
        neg_next       = neg_reg;
        sin_sum_next   = sin_sum_reg;
        qx_next        = qx_reg;
        qy_next        = qy_reg;
        empty_next     = empty_reg;
        res_valid_next = res_valid_reg && res_stall;
        res_next       = res_reg;
        pop            = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (!qstat.empty)
                begin
                    pop          = 1'b1;
                    empty_next   = (head.total == '0);
                    sin_sum_next = head.sum_sin;
                    div_next     = {head.total, 1'b0};
                    num_next     = div_num(head.sum_cos, head.total);
                    neg_next     = head.sum_cos[SUM_W-1];
                    rem_next     = '0;
                    cnt_next     = '0;
                    comp_next    = 1'b0;
                    if (head.total == '0)
                    begin
                        qx_next    = '0;
                        qy_next    = '0;
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        state_next = ST_DIV;
                    end
                end
            end
            ST_DIV:
            begin
                rem_next = rem_step;
                num_next = num_step;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(DIV_STEPS - 1))
                begin
                    if (!comp_reg)
                    begin
                        qx_next   = q_sat;
                        comp_next = 1'b1;
                        num_next  = div_num(sin_sum_reg, div_reg[DIV_W-1:1]);
                        neg_next  = sin_sum_reg[SUM_W-1];
                        rem_next  = '0;
                        cnt_next  = '0;
                    end
                    else
                    begin
                        qy_next    = q_sat;
                        state_next = ST_DONE;
                    end
                end
            end
            ST_DONE:
            begin
                if (!res_valid_reg || !res_stall)
                begin
                    res_valid_next     = 1'b1;
                    res_next.q_x       = qx_reg;
                    res_next.q_y       = qy_reg;
                    res_next.empty_res = empty_reg;
                    state_next         = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            res_valid_reg <= 1'b0;
            comp_reg      <= 1'b0;
            cnt_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            res_valid_reg <= res_valid_next;
            comp_reg      <= comp_next;
            cnt_reg       <= cnt_next;
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        num_reg     <= num_next;
        rem_reg     <= rem_next;
        div_reg     <= div_next;
        neg_reg     <= neg_next;
        sin_sum_reg <= sin_sum_next;
        qx_reg      <= qx_next;
        qy_reg      <= qy_next;
        empty_reg   <= empty_next;
        res_reg     <= res_next;
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

endmodule

`default_nettype wire

// File: src/charge_weighted_flow_vector_top.sv
// Throughput: one hit request per cycle when not stalled; events queue up to four deep.
// An event's result follows its last hit through the lookup and product stages,
// the queue, a pop, 2 x 35 divider steps and 1 output register; res_stall can hold it.
// The shared one-bit-per-cycle divider runs cosine then sine; an empty event skips it.
// Reset: asynchronous, active low; clears accumulators, queue and sequencer.
`default_nettype none

module charge_weighted_flow_vector_top #(
    parameter int CHARGE_BITS = 12
) (
    input  wire                 clk,
    input  wire                 rst_n,
    input  wire                 hit_valid,
    output logic                hit_stall,
    input  cwfv_pkg::in_t       hit,
    output logic                res_valid,
    input  wire                 res_stall,
    output cwfv_pkg::out_t      res
);
    import cwfv_pkg::*;

    logic   push;
    logic   pop;
    evt_t   evt;
    evt_t   head;
    qstat_t qstat;

    // Hit intake and accumulation
    cwfv_front #(
        .CHARGE_BITS (CHARGE_BITS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .hit_valid (hit_valid),
        .hit_stall (hit_stall),
        .hit       (hit),
        .qstat     (qstat),
        .push      (push),
        .evt       (evt)
    );

    // Finished events awaiting normalization
    cwfv_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .evt   (evt),
        .pop   (pop),
        .head  (head),
        .qstat (qstat)
    );

    // Normalization and result output
    cwfv_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head      (head),
        .qstat     (qstat),
        .pop       (pop),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res       (res)
    );

endmodule

`default_nettype wire
